// ----- src/efws_pkg.sv -----
// Shared types, constants and saturating helpers for the Euler flux pipeline.
package efws_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int QUO_BITS   = WORD_BITS + FRAC_BITS;
  localparam int ROOT_BITS  = QUO_BITS / 2;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int DIV_STEPS  = QUO_BITS;
  localparam int SQRT_STEPS = ROOT_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;

  // Direction codes; code three is folded onto z
  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;
  localparam logic [1:0] DIR_Z = 2'd2;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_DENSITY  = 2'd1,
    FAULT_PRESSURE = 2'd2
  } fault_t;

  localparam mag_t  SAT_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // floor(x/5) = (x * ceil(2^k/5)) >> k, exact over the input range used
  localparam int          FIFTH2_SHIFT = 35;
  localparam logic [32:0] FIFTH2_RECIP = 33'd6871947674;
  localparam int          FIFTH7_SHIFT = 37;
  localparam logic [34:0] FIFTH7_RECIP = 35'd27487790695;

  typedef struct packed {
    word_t      density;
    word_t      momentum_x;
    word_t      momentum_y;
    word_t      momentum_z;
    word_t      energy;
    logic [1:0] direction;
  } in_t;

  typedef struct packed {
    word_t  flux_mass;
    word_t  flux_mom_x;
    word_t  flux_mom_y;
    word_t  flux_mom_z;
    word_t  flux_energy;
    word_t  speed_low;
    word_t  speed_mid;
    word_t  speed_high;
    fault_t fault;
  } out_t;

  function automatic mag_t mag_of(word_t x);
    return x[WORD_BITS-1] ? (~mag_t'(x) + 1'b1) : mag_t'(x);
  endfunction

  function automatic word_t apply_sign(mag_t m, logic neg);
    return neg ? word_t'(~m + 1'b1) : word_t'(m);
  endfunction

  // Sign and magnitude to word, saturated
  function automatic word_t sat_mag(logic [QUO_BITS-1:0] m, logic neg);
    logic [QUO_BITS-1:0] lim;
    lim = {{FRAC_BITS{1'b0}}, SAT_MAX} + QUO_BITS'(neg);
    if (m > lim) return neg ? WORD_MIN : WORD_MAX;
    return apply_sign(m[WORD_BITS-1:0], neg);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

endpackage

// ----- src/efws_div_cell.sv -----
// One restoring-division cell: one quotient bit per lane, shared divisor.
module efws_div_cell #(
  parameter int LANES = 1,
  parameter int DEN_W = 32,
  parameter int NQ_W  = 48
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [DEN_W-1:0]             den_in,
  input  logic [LANES-1:0][DEN_W-1:0]  rem_in,
  input  logic [LANES-1:0][NQ_W-1:0]   nq_in,
  output logic [DEN_W-1:0]             den_out,
  output logic [LANES-1:0][DEN_W-1:0]  rem_out,
  output logic [LANES-1:0][NQ_W-1:0]   nq_out
);

  logic [LANES-1:0][DEN_W:0]   shifted;
  logic [LANES-1:0][DEN_W:0]   diff;
  logic [LANES-1:0][DEN_W-1:0] rem_next;
  logic [LANES-1:0][NQ_W-1:0]  nq_next;

  // Shift in the next numerator bit, subtract when it fits; quotient bit enters at the bottom
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shifted[l] = {rem_in[l], nq_in[l][NQ_W-1]};
      diff[l]    = shifted[l] - {1'b0, den_in};
      if (shifted[l] >= {1'b0, den_in}) begin
        rem_next[l] = diff[l][DEN_W-1:0];
        nq_next[l]  = {nq_in[l][NQ_W-2:0], 1'b1};
      end else begin
        rem_next[l] = shifted[l][DEN_W-1:0];
        nq_next[l]  = {nq_in[l][NQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= rem_next;
      nq_out  <= nq_next;
    end
  end

endmodule

// ----- src/efws_sqrt_cell.sv -----
// One digit-by-digit square root cell: one root bit from two radicand bits.
module efws_sqrt_cell #(
  parameter int ROOT_W = 24
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad_in,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  output logic [2*ROOT_W-1:0]   rad_out,
  output logic [ROOT_W+1:0]     rem_out,
  output logic [ROOT_W-1:0]     root_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W+1:0] shifted;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic [REM_W-1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  // Trial subtract of 4*root+1 from the remainder with two new bits
  always_comb begin
    shifted = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial   = {2'b00, root_in, 2'b01};
    diff    = shifted - trial;
    if (shifted >= trial) begin
      rem_next  = diff[REM_W-1:0];
      root_next = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = shifted[REM_W-1:0];
      root_next = {root_in[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

// ----- src/euler_flux_and_wave_speeds_core.sv -----
// Top level: ideal-gas Euler flux column and wave speeds, one cell state per cycle unless the output stalls.
//
// Input channel item/item_valid/item_ready carries one cell state (density,
// momentum x/y/z, total energy, all signed Q16.16) and a direction (0 x,
// 1 y, 2 z, 3 taken as z). Output channel result/result_valid/result_ready
// carries the flux column for that direction, the wave speeds u-c, u, u+c
// and a fault code (density not positive, or pressure negative).
// Throughput is one item per cycle while the receiver does not stall the
// output. From input transfer to result an item passes an input register,
// a 48-cell division row for the three velocities, ten arithmetic stages
// (products, kinetic energy, pressure, fluxes), a 48-cell division row for
// c^2, one stage, a 24-cell square root row and the output register. The
// two division rows and the root row set the latency.
// When the receiver holds result_ready low with a result waiting, the whole
// row freezes and item_ready falls; no result is lost or repeated.
// Reset empties the pipeline; results in flight are dropped.
module euler_flux_and_wave_speeds_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  efws_pkg::in_t   item,
  output logic            result_valid,
  input  logic            result_ready,
  output efws_pkg::out_t  result
);

  localparam int W   = efws_pkg::WORD_BITS;
  localparam int F   = efws_pkg::FRAC_BITS;
  localparam int QW  = efws_pkg::QUO_BITS;
  localparam int PW  = efws_pkg::PROD_BITS;
  localparam int RW  = efws_pkg::ROOT_BITS;
  localparam int DN  = efws_pkg::DIV_STEPS;
  localparam int SN  = efws_pkg::SQRT_STEPS;

  typedef struct packed {
    efws_pkg::word_t       rho;
    efws_pkg::word_t [2:0] j;
    efws_pkg::mag_t  [2:0] jm;
    logic            [2:0] jn;
    efws_pkg::word_t       e;
    logic            [1:0] d;
  } side_t;

  typedef struct packed {
    efws_pkg::word_t [4:0] flux;
    efws_pkg::mag_t        umd;
    logic                  und;
    efws_pkg::fault_t      fault;
  } pay_t;

  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // ---------------- input register ----------------
  logic  s0_v;
  side_t s0;
  side_t s0_next;

  always_comb begin
    s0_next.rho  = item.density;
    s0_next.j[0] = item.momentum_x;
    s0_next.j[1] = item.momentum_y;
    s0_next.j[2] = item.momentum_z;
    s0_next.e    = item.energy;
    s0_next.d    = (item.direction > efws_pkg::DIR_Z) ? efws_pkg::DIR_Z : item.direction;
    for (int i = 0; i < 3; i++) begin
      s0_next.jm[i] = efws_pkg::mag_of(s0_next.j[i]);
      s0_next.jn[i] = s0_next.j[i][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s0 <= s0_next;
  end

  // ---------------- velocity division row ----------------
  logic [W-1:0]          d1_den [DN+1];
  logic [2:0][W-1:0]     d1_rem [DN+1];
  logic [2:0][QW-1:0]    d1_nq  [DN+1];
  side_t                 d1_side [DN];
  logic [DN-1:0]         d1_v;

  assign d1_den[0] = efws_pkg::mag_t'(s0.rho);
  assign d1_rem[0] = '0;
  always_comb begin
    for (int i = 0; i < 3; i++) d1_nq[0][i] = {s0.jm[i], {F{1'b0}}};
  end

  for (genvar k = 0; k < DN; k++) begin : g_div1
    efws_div_cell #(.LANES(3), .DEN_W(W), .NQ_W(QW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .den_in  (d1_den[k]),
      .rem_in  (d1_rem[k]),
      .nq_in   (d1_nq[k]),
      .den_out (d1_den[k+1]),
      .rem_out (d1_rem[k+1]),
      .nq_out  (d1_nq[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= '0;
    end else if (adv) begin
      d1_v <= {d1_v[DN-2:0], s0_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_side[0] <= s0;
      for (int k = 1; k < DN; k++) d1_side[k] <= d1_side[k-1];
    end
  end

  // ---------------- U: saturate velocity magnitudes ----------------
  logic                 u_v;
  side_t                u_s;
  efws_pkg::mag_t [2:0] u_um;
  efws_pkg::mag_t [2:0] u_um_next;
  logic [QW-1:0]        u_lim [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_lim[i] = {{F{1'b0}}, efws_pkg::SAT_MAX} + QW'(d1_side[DN-1].jn[i]);
      u_um_next[i] = (d1_nq[DN][i] > u_lim[i]) ? u_lim[i][W-1:0] : d1_nq[DN][i][W-1:0];
    end
  end

  // ---------------- MA: products ----------------
  logic                  ma_v;
  side_t                 ma_s;
  efws_pkg::mag_t        ma_umd;
  logic [2:0][PW-1:0]    ma_pk;
  logic [2:0][PW-1:0]    ma_pf;

  // ---------------- MB: fixed-point scaling ----------------
  logic                  mb_v;
  side_t                 mb_s;
  efws_pkg::mag_t        mb_umd;
  efws_pkg::word_t [2:0] mb_ke;
  efws_pkg::word_t [2:0] mb_fl;

  // ---------------- K: kinetic energy ----------------
  logic                  k_v;
  side_t                 k_s;
  efws_pkg::mag_t        k_umd;
  efws_pkg::word_t [2:0] k_fl;
  efws_pkg::word_t       k_ke;

  // ---------------- V: E - ke ----------------
  logic                  v_v;
  side_t                 v_s;
  efws_pkg::mag_t        v_umd;
  efws_pkg::word_t [2:0] v_fl;
  efws_pkg::mag_t        v_vm;
  logic                  v_vn;
  efws_pkg::word_t       v_diff;

  // ---------------- PM / PF: pressure ----------------
  logic                  pm_v;
  side_t                 pm_s;
  efws_pkg::mag_t        pm_umd;
  efws_pkg::word_t [2:0] pm_fl;
  efws_pkg::mag_t        pm_pm;
  logic                  pm_vn;
  logic [65:0]           pm_prod;

  logic                  pf_v;
  side_t                 pf_s;
  efws_pkg::mag_t        pf_umd;
  efws_pkg::word_t [2:0] pf_fl;
  efws_pkg::word_t       pf_p;

  always_comb begin
    pm_prod = 66'({v_vm, 1'b0}) * 66'(efws_pkg::FIFTH2_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_v  <= 1'b0;
      ma_v <= 1'b0;
      mb_v <= 1'b0;
      k_v  <= 1'b0;
      v_v  <= 1'b0;
      pm_v <= 1'b0;
      pf_v <= 1'b0;
    end else if (adv) begin
      u_v  <= d1_v[DN-1];
      ma_v <= u_v;
      mb_v <= ma_v;
      k_v  <= mb_v;
      v_v  <= k_v;
      pm_v <= v_v;
      pf_v <= pm_v;
    end
  end

  assign v_diff = efws_pkg::sat_sub(k_s.e, k_ke);

  // Arithmetic stages between the two division rows
  always_ff @(posedge clk) begin
    if (adv) begin
      u_s  <= d1_side[DN-1];
      u_um <= u_um_next;

      ma_s   <= u_s;
      ma_umd <= u_um[u_s.d];
      for (int i = 0; i < 3; i++) begin
        ma_pk[i] <= PW'(u_um[i]) * PW'(u_s.jm[i]);
        ma_pf[i] <= PW'(u_um[u_s.d]) * PW'(u_s.jm[i]);
      end

      mb_s   <= ma_s;
      mb_umd <= ma_umd;
      for (int i = 0; i < 3; i++) begin
        mb_ke[i] <= efws_pkg::sat_mag(ma_pk[i][PW-1:F], 1'b0);
        mb_fl[i] <= efws_pkg::sat_mag(ma_pf[i][PW-1:F], ma_s.jn[i] ^ ma_s.jn[ma_s.d]);
      end

      // terms are nonnegative, so halving is a shift
      k_s   <= mb_s;
      k_umd <= mb_umd;
      k_fl  <= mb_fl;
      k_ke  <= efws_pkg::sat_add(efws_pkg::sat_add(mb_ke[0], mb_ke[1]), mb_ke[2]) >>> 1;

      v_s   <= k_s;
      v_umd <= k_umd;
      v_fl  <= k_fl;
      v_vm  <= efws_pkg::mag_of(v_diff);
      v_vn  <= v_diff[W-1];

      pm_s   <= v_s;
      pm_umd <= v_umd;
      pm_fl  <= v_fl;
      pm_pm  <= efws_pkg::mag_t'(pm_prod[65:efws_pkg::FIFTH2_SHIFT]);
      pm_vn  <= v_vn;

      pf_s   <= pm_s;
      pf_umd <= pm_umd;
      pf_fl  <= pm_fl;
      pf_p   <= efws_pkg::apply_sign(pm_pm, pm_vn);
    end
  end

  // ---------------- F1..F3: fluxes and c^2 numerator ----------------
  logic                  f1_v;
  efws_pkg::word_t [3:0] f1_flux;
  efws_pkg::mag_t        f1_umd;
  logic                  f1_und;
  efws_pkg::word_t       f1_rho;
  efws_pkg::fault_t      f1_fault;
  efws_pkg::mag_t        f1_esm;
  logic                  f1_esn;
  logic [W+1:0]          f1_x7;
  efws_pkg::word_t       f1_es;
  efws_pkg::fault_t      f1_fault_next;
  efws_pkg::mag_t        pf_pm;

  logic                  f2_v;
  efws_pkg::word_t [3:0] f2_flux;
  efws_pkg::mag_t        f2_umd;
  logic                  f2_und;
  efws_pkg::word_t       f2_rho;
  efws_pkg::fault_t      f2_fault;
  logic                  f2_esn;
  logic [PW-1:0]         f2_pe;
  efws_pkg::mag_t        f2_q7;
  logic [68:0]           f2_prod;

  logic                  f3_v;
  pay_t                  f3_pay;
  efws_pkg::word_t       f3_rho;
  efws_pkg::mag_t        f3_a;

  always_comb begin
    f1_es  = efws_pkg::sat_add(pf_s.e, pf_p);
    pf_pm  = efws_pkg::mag_of(pf_p);
    if (pf_s.rho[W-1] || pf_s.rho == '0) begin
      f1_fault_next = efws_pkg::FAULT_DENSITY;
    end else if (pf_p[W-1]) begin
      f1_fault_next = efws_pkg::FAULT_PRESSURE;
    end else begin
      f1_fault_next = efws_pkg::FAULT_NONE;
    end
    f2_prod = 69'(f1_x7) * 69'(efws_pkg::FIFTH7_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else if (adv) begin
      f1_v <= pf_v;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // pressure joins the momentum row along the direction
      f1_flux[0] <= pf_s.j[pf_s.d];
      for (int i = 0; i < 3; i++) begin
        f1_flux[i+1] <= (2'(i) == pf_s.d) ? efws_pkg::sat_add(pf_fl[i], pf_p) : pf_fl[i];
      end
      f1_umd   <= pf_umd;
      f1_und   <= pf_s.jn[pf_s.d];
      f1_rho   <= pf_s.rho;
      f1_fault <= f1_fault_next;
      f1_esm   <= efws_pkg::mag_of(f1_es);
      f1_esn   <= f1_es[W-1];
      f1_x7    <= {pf_pm, 2'b00} + {1'b0, pf_pm, 1'b0} + {2'b00, pf_pm};

      f2_flux  <= f1_flux;
      f2_umd   <= f1_umd;
      f2_und   <= f1_und;
      f2_rho   <= f1_rho;
      f2_fault <= f1_fault;
      f2_esn   <= f1_esn;
      f2_pe    <= PW'(f1_esm) * PW'(f1_umd);
      f2_q7    <= f2_prod[efws_pkg::FIFTH7_SHIFT +: W];

      f3_pay.flux[3:0] <= f2_flux;
      f3_pay.flux[4]   <= efws_pkg::sat_mag(f2_pe[PW-1:F], f2_esn ^ f2_und);
      f3_pay.umd       <= f2_umd;
      f3_pay.und       <= f2_und;
      f3_pay.fault     <= f2_fault;
      f3_rho           <= f2_rho;
      f3_a             <= (f2_q7 > efws_pkg::SAT_MAX) ? efws_pkg::SAT_MAX : f2_q7;
    end
  end

  // ---------------- c^2 division row ----------------
  logic [W-1:0]          d2_den [DN+1];
  logic [0:0][W-1:0]     d2_rem [DN+1];
  logic [0:0][QW-1:0]    d2_nq  [DN+1];
  pay_t                  d2_pay [DN];
  logic [DN-1:0]         d2_v;

  assign d2_den[0]    = efws_pkg::mag_t'(f3_rho);
  assign d2_rem[0]    = '0;
  assign d2_nq[0][0]  = {f3_a, {F{1'b0}}};

  for (genvar k = 0; k < DN; k++) begin : g_div2
    efws_div_cell #(.LANES(1), .DEN_W(W), .NQ_W(QW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .den_in  (d2_den[k]),
      .rem_in  (d2_rem[k]),
      .nq_in   (d2_nq[k]),
      .den_out (d2_den[k+1]),
      .rem_out (d2_rem[k+1]),
      .nq_out  (d2_nq[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v <= '0;
    end else if (adv) begin
      d2_v <= {d2_v[DN-2:0], f3_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_pay[0] <= f3_pay;
      for (int k = 1; k < DN; k++) d2_pay[k] <= d2_pay[k-1];
    end
  end

  // ---------------- C: saturate c^2 ----------------
  logic           c_v;
  pay_t           c_pay;
  efws_pkg::mag_t c_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= d2_v[DN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pay <= d2_pay[DN-1];
      c_c2  <= (d2_nq[DN][0] > {{F{1'b0}}, efws_pkg::SAT_MAX}) ?
               efws_pkg::SAT_MAX : d2_nq[DN][0][W-1:0];
    end
  end

  // ---------------- square root row ----------------
  logic [2*RW-1:0] sq_rad  [SN+1];
  logic [RW+1:0]   sq_rem  [SN+1];
  logic [RW-1:0]   sq_root [SN+1];
  pay_t            sq_pay  [SN];
  logic [SN-1:0]   sq_v;

  assign sq_rad[0]  = {c_c2, {F{1'b0}}};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SN; k++) begin : g_sqrt
    efws_sqrt_cell #(.ROOT_W(RW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (adv) begin
      sq_v <= {sq_v[SN-2:0], c_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pay[0] <= c_pay;
      for (int k = 1; k < SN; k++) sq_pay[k] <= sq_pay[k-1];
    end
  end

  // ---------------- output register ----------------
  pay_t            o_pay;
  efws_pkg::word_t o_c;
  efws_pkg::word_t o_ud;
  efws_pkg::out_t  result_next;

  always_comb begin
    o_pay = sq_pay[SN-1];
    o_c   = efws_pkg::word_t'({{(W-RW){1'b0}}, sq_root[SN]});
    o_ud  = efws_pkg::apply_sign(o_pay.umd, o_pay.und);
    result_next.flux_mass   = o_pay.flux[0];
    result_next.flux_mom_x  = o_pay.flux[1];
    result_next.flux_mom_y  = o_pay.flux[2];
    result_next.flux_mom_z  = o_pay.flux[3];
    result_next.flux_energy = o_pay.flux[4];
    result_next.speed_low   = efws_pkg::sat_sub(o_ud, o_c);
    result_next.speed_mid   = o_ud;
    result_next.speed_high  = efws_pkg::sat_add(o_ud, o_c);
    result_next.fault       = o_pay.fault;
    if (o_pay.fault != efws_pkg::FAULT_NONE) begin
      result_next.speed_low  = '0;
      result_next.speed_mid  = '0;
      result_next.speed_high = '0;
    end
    if (o_pay.fault == efws_pkg::FAULT_DENSITY) begin
      result_next.flux_mass   = '0;
      result_next.flux_mom_x  = '0;
      result_next.flux_mom_y  = '0;
      result_next.flux_mom_z  = '0;
      result_next.flux_energy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= sq_v[SN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) result <= result_next;
  end

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_density_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fault == efws_pkg::FAULT_DENSITY |->
      result.flux_mass == '0 && result.flux_mom_x == '0 && result.flux_mom_y == '0 &&
      result.flux_mom_z == '0 && result.flux_energy == '0)
    else $error("flux not cleared on density fault");

  a_fault_speeds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fault != efws_pkg::FAULT_NONE |->
      result.speed_low == '0 && result.speed_mid == '0 && result.speed_high == '0)
    else $error("speeds not cleared on fault");

  a_speed_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fault == efws_pkg::FAULT_NONE |->
      result.speed_low <= result.speed_mid && result.speed_mid <= result.speed_high)
    else $error("wave speeds out of order");

endmodule
